>>> rtl/ffsa_pkg.sv
// Shared types and constants for the first-fit segment allocator.
// Used by ffsa_ctrl, ffsa_dp and first_fit_segment_allocator; depends on nothing.
package ffsa_pkg;

    localparam int HEAP_BYTES   = 65536;
    localparam int MAX_SEGMENTS = 64;
    localparam int OFF_W        = 16;
    localparam int SIZE_W       = 17;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_FAIL = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic [OFF_W-1:0]  off;
        logic [SIZE_W-1:0] size;
        logic              used;
    } t_seg;

    typedef enum logic [2:0] {
        RD_IDX,
        RD_NEXT,
        RD_PREV,
        RD_SP,
        RD_SP1
    } t_rd_sel;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_INIT,
        WR_SHIFT,
        WR_DROP,
        WR_REST,
        WR_GRANT,
        WR_LMERGE,
        WR_FREE
    } t_wr_sel;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_A_NB,
        S_A_OPEN,
        S_SH_RD,
        S_SH_WR,
        S_WR_REST,
        S_WR_GRANT,
        S_R_NB,
        S_DR_RD,
        S_DR_WR,
        S_L_START,
        S_L_NB,
        S_WR_FREE,
        S_RESP
    } t_state;

    typedef struct packed {
        logic    load;
        logic    idx_inc;
        logic    take_cur;
        logic    take_nb;
        logic    cur_add;
        logic    sp_top;
        logic    sp_idx;
        logic    sp_idx1;
        logic    sp_inc;
        logic    sp_dec;
        logic    cnt_dec;
        logic    set_res;
        logic    grant;
        t_status res;
        t_rd_sel rd_sel;
        t_wr_sel wr_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic q_used;
        logic size_lt;
        logic size_eq;
        logic off_eq;
        logic has_next;
        logic has_prev;
        logic full;
        logic idx_end;
        logic req_zero;
        logic is_free;
        logic sp_at_idx;
        logic sp_last;
    } t_dp_stat;

endpackage

>>> rtl/ffsa_dp.sv
// Datapath of the allocator: segment table memory, scan index, shift pointer,
// entry count and result registers. Depends on ffsa_pkg; driven by ffsa_ctrl.
module ffsa_dp import ffsa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic                i_mode,
    input  logic [SIZE_W-1:0]   i_request_size,
    input  logic [OFF_W-1:0]    i_block_offset,
    output t_dp_stat            o_stat,
    output logic [1:0]          o_status,
    output logic [OFF_W-1:0]    o_granted_offset
);

    t_seg                r_mem [MAX_SEGMENTS];
    t_seg                r_q;
    t_seg                r_cur;
    logic [SIZE_W-1:0]   r_nb_size;
    logic                r_merge;
    logic [CNT_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_sp;
    logic [CNT_W-1:0]    r_count;
    logic                r_mode;
    logic [SIZE_W-1:0]   r_req;
    logic [OFF_W-1:0]    r_off;
    t_status             r_status;
    logic [OFF_W-1:0]    r_granted;

    logic [CNT_W-1:0]    w_idx_p1;
    logic [CNT_W-1:0]    w_idx_m1;
    logic [CNT_W-1:0]    w_sp_p1;
    logic [CNT_W-1:0]    w_rd_addr;
    logic [CNT_W-1:0]    w_wr_addr;
    logic                w_we;
    t_seg                w_wd;
    logic [SIZE_W-1:0]   w_rest_size;
    logic [OFF_W-1:0]    w_rest_off;

    assign w_idx_p1    = r_idx + 1'b1;
    assign w_idx_m1    = r_idx - 1'b1;
    assign w_sp_p1     = r_sp + 1'b1;
    assign w_rest_size = r_cur.size - r_req;
    assign w_rest_off  = OFF_W'({1'b0, r_cur.off} + r_req);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_IDX:  w_rd_addr = r_idx;
            RD_NEXT: w_rd_addr = w_idx_p1;
            RD_PREV: w_rd_addr = w_idx_m1;
            RD_SP:   w_rd_addr = r_sp;
            RD_SP1:  w_rd_addr = w_sp_p1;
            default: w_rd_addr = r_idx;
        endcase
    end

    always_comb begin
        w_we      = 1'b1;
        w_wr_addr = r_idx;
        w_wd      = r_cur;
        case (i_cmd.wr_sel)
            WR_INIT: begin
                w_wr_addr = '0;
                w_wd      = '{off: '0, size: SIZE_W'(HEAP_BYTES), used: 1'b0};
            end
            WR_SHIFT: begin
                w_wr_addr = w_sp_p1;
                w_wd      = r_q;
            end
            WR_DROP: begin
                w_wr_addr = r_sp;
                w_wd      = r_q;
            end
            WR_REST: begin
                w_wr_addr = w_idx_p1;
                w_wd      = '{off: w_rest_off,
                              size: w_rest_size + (r_merge ? r_nb_size : '0),
                              used: 1'b0};
            end
            WR_GRANT: begin
                w_wd = '{off: r_cur.off, size: r_req, used: 1'b1};
            end
            WR_LMERGE: begin
                w_wr_addr = w_idx_m1;
                w_wd      = '{off: r_q.off, size: r_q.size + r_cur.size, used: 1'b0};
            end
            WR_FREE: begin
                w_wd = '{off: r_cur.off, size: r_cur.size, used: 1'b0};
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Table memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr[IDX_W-1:0]] <= w_wd;
        end
        r_q <= r_mem[w_rd_addr[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_req  <= i_request_size;
            r_off  <= i_block_offset;
        end
        if (i_cmd.take_cur) begin
            r_cur <= r_q;
        end else if (i_cmd.cur_add) begin
            r_cur.size <= r_cur.size + r_q.size;
        end
        if (i_cmd.take_nb) begin
            r_nb_size <= r_q.size;
        end
        if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= w_idx_p1;
        end
        if (i_cmd.sp_top) begin
            r_sp <= r_count - 1'b1;
        end else if (i_cmd.sp_idx) begin
            r_sp <= r_idx;
        end else if (i_cmd.sp_idx1) begin
            r_sp <= w_idx_p1;
        end else if (i_cmd.sp_inc) begin
            r_sp <= w_sp_p1;
        end else if (i_cmd.sp_dec) begin
            r_sp <= r_sp - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= CNT_W'(1);
            r_merge   <= 1'b0;
            r_status  <= ST_DONE;
            r_granted <= '0;
        end else begin
            if (i_cmd.wr_sel == WR_INIT) begin
                r_count <= CNT_W'(1);
            end else if (i_cmd.wr_sel == WR_REST && !r_merge) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.load || i_cmd.sp_top) begin
                r_merge <= 1'b0;
            end else if (i_cmd.take_nb) begin
                r_merge <= 1'b1;
            end
            if (i_cmd.set_res) begin
                r_status  <= i_cmd.res;
                r_granted <= i_cmd.grant ? r_cur.off : '0;
            end
        end
    end

    always_comb begin
        o_stat.q_used    = r_q.used;
        o_stat.size_lt   = r_q.size < r_req;
        o_stat.size_eq   = r_q.size == r_req;
        o_stat.off_eq    = r_q.off == r_off;
        o_stat.has_next  = w_idx_p1 < r_count;
        o_stat.has_prev  = r_idx != '0;
        o_stat.full      = r_count == CNT_W'(MAX_SEGMENTS);
        o_stat.idx_end   = r_idx >= r_count;
        o_stat.req_zero  = r_req == '0;
        o_stat.is_free   = r_mode == MODE_FREE;
        o_stat.sp_at_idx = r_sp == r_idx;
        o_stat.sp_last   = w_sp_p1 >= r_count;
    end

    assign o_status         = r_status;
    assign o_granted_offset = r_granted;

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= CNT_W'(MAX_SEGMENTS)))
        else $error("segment count out of range");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count)) ||
                           (r_count == $past(r_count) + 1'b1) ||
                           (r_count == $past(r_count) - 1'b1))
        else $error("segment count moved by more than one");

    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status != ST_DONE) |-> (r_granted == '0))
        else $error("granted offset set on a failed request");
`endif

endmodule

>>> rtl/ffsa_ctrl.sv
// Controller state machine of the allocator: sequences scan, table shifts,
// merges and the result handshake. Depends on ffsa_pkg; commands ffsa_dp.
module ffsa_ctrl import ffsa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    output logic     o_valid,
    input  logic     i_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_left;
    logic   n_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_left  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: n_state = S_IDLE;
            S_IDLE: begin
                if (i_valid) n_state = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                if ((!i_stat.is_free && i_stat.req_zero) || i_stat.idx_end) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (i_stat.is_free) begin
                    if (!i_stat.off_eq)       n_state = S_SCAN_RD;
                    else if (i_stat.has_next) n_state = S_R_NB;
                    else                      n_state = S_L_START;
                end else begin
                    if (i_stat.q_used || i_stat.size_lt) n_state = S_SCAN_RD;
                    else if (i_stat.size_eq)             n_state = S_WR_GRANT;
                    else if (i_stat.has_next)            n_state = S_A_NB;
                    else                                 n_state = S_A_OPEN;
                end
            end
            S_A_NB:     n_state = i_stat.q_used ? S_A_OPEN : S_WR_REST;
            S_A_OPEN:   n_state = i_stat.full ? S_RESP : S_SH_RD;
            S_SH_RD:    n_state = i_stat.sp_at_idx ? S_WR_REST : S_SH_WR;
            S_SH_WR:    n_state = S_SH_RD;
            S_WR_REST:  n_state = S_WR_GRANT;
            S_WR_GRANT: n_state = S_RESP;
            S_R_NB:     n_state = i_stat.q_used ? S_L_START : S_DR_RD;
            S_DR_RD: begin
                if (!i_stat.sp_last) n_state = S_DR_WR;
                else if (r_left)     n_state = S_RESP;
                else                 n_state = S_L_START;
            end
            S_DR_WR:    n_state = S_DR_RD;
            S_L_START:  n_state = i_stat.has_prev ? S_L_NB : S_WR_FREE;
            S_L_NB:     n_state = i_stat.q_used ? S_WR_FREE : S_DR_RD;
            S_WR_FREE:  n_state = S_RESP;
            S_RESP: begin
                if (!i_stall) n_state = S_IDLE;
            end
            default:    n_state = S_INIT;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        n_left = r_left;
        case (r_state)
            S_INIT: o_cmd.wr_sel = WR_INIT;
            S_IDLE: o_cmd.load = i_valid;
            S_SCAN_RD: begin
                if ((!i_stat.is_free && i_stat.req_zero) || i_stat.idx_end) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res     = ST_FAIL;
                end else begin
                    o_cmd.rd_sel = RD_IDX;
                end
            end
            S_SCAN_CHK: begin
                o_cmd.take_cur = 1'b1;
                if (i_stat.is_free) begin
                    if (!i_stat.off_eq)       o_cmd.idx_inc = 1'b1;
                    else if (i_stat.has_next) o_cmd.rd_sel  = RD_NEXT;
                end else begin
                    if (i_stat.q_used || i_stat.size_lt) begin
                        o_cmd.idx_inc = 1'b1;
                    end else if (!i_stat.size_eq && i_stat.has_next) begin
                        o_cmd.rd_sel = RD_NEXT;
                    end
                end
            end
            S_A_NB: o_cmd.take_nb = !i_stat.q_used;
            S_A_OPEN: begin
                if (i_stat.full) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res     = ST_FULL;
                end else begin
                    o_cmd.sp_top = 1'b1;
                end
            end
            S_SH_RD: o_cmd.rd_sel = RD_SP;
            S_SH_WR: begin
                o_cmd.wr_sel = WR_SHIFT;
                o_cmd.sp_dec = 1'b1;
            end
            S_WR_REST: o_cmd.wr_sel = WR_REST;
            S_WR_GRANT: begin
                o_cmd.wr_sel  = WR_GRANT;
                o_cmd.set_res = 1'b1;
                o_cmd.res     = ST_DONE;
                o_cmd.grant   = 1'b1;
            end
            S_R_NB: begin
                if (!i_stat.q_used) begin
                    o_cmd.cur_add = 1'b1;
                    o_cmd.sp_idx1 = 1'b1;
                    n_left        = 1'b0;
                end
            end
            S_DR_RD: begin
                if (i_stat.sp_last) begin
                    o_cmd.cnt_dec = 1'b1;
                    o_cmd.set_res = r_left;
                    o_cmd.res     = ST_DONE;
                end else begin
                    o_cmd.rd_sel = RD_SP1;
                end
            end
            S_DR_WR: begin
                o_cmd.wr_sel = WR_DROP;
                o_cmd.sp_inc = 1'b1;
            end
            S_L_START: o_cmd.rd_sel = RD_PREV;
            S_L_NB: begin
                if (!i_stat.q_used) begin
                    o_cmd.wr_sel = WR_LMERGE;
                    o_cmd.sp_idx = 1'b1;
                    n_left       = 1'b1;
                end
            end
            S_WR_FREE: begin
                o_cmd.wr_sel  = WR_FREE;
                o_cmd.set_res = 1'b1;
                o_cmd.res     = ST_DONE;
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_stall = r_state != S_IDLE;
    assign o_valid = r_state == S_RESP;

endmodule

>>> rtl/first_fit_segment_allocator.sv
// Top level of the first-fit segment allocator with coalescing.
// Depends on ffsa_pkg, ffsa_ctrl and ffsa_dp.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+---------------------------------------
//   request | in        | i_valid / o_stall  | i_mode, i_request_size, i_block_offset
//   result  | out       | o_valid / i_stall  | o_status, o_granted_offset
//
// One item is handled at a time. The table scan handles each segment visited as a memory read,
// then a compare, and each entry moved when a segment is
// inserted or removed is read and then written one entry over.
// After reset the whole-heap free segment is written into entry zero;
// o_stall stays high during it. A result waits in its register while i_stall
// is high, and no new request is taken until it has been delivered.
module first_fit_segment_allocator import ffsa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_mode,
    input  logic [SIZE_W-1:0]   i_request_size,
    input  logic [OFF_W-1:0]    i_block_offset,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_status,
    output logic [OFF_W-1:0]    o_granted_offset
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    ffsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    ffsa_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_mode           (i_mode),
        .i_request_size   (i_request_size),
        .i_block_offset   (i_block_offset),
        .o_stat           (w_stat),
        .o_status         (o_status),
        .o_granted_offset (o_granted_offset)
    );

endmodule

>>> tb/first_fit_segment_allocator_tb.sv
// Self-checking testbench for the first-fit segment allocator with coalescing.
// Depends on ffsa_pkg and first_fit_segment_allocator; keeps its own segment table
// and checks every returned item against it.
module first_fit_segment_allocator_tb;
    import ffsa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic              mode;
        logic [SIZE_W-1:0] req_size;
        logic [OFF_W-1:0]  blk_off;
    } t_req;

    typedef struct {
        t_status          status;
        logic [OFF_W-1:0] granted;
    } t_grant;

    localparam int CYCLE_LIMIT = 1500000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              in_mode = 1'b0;
    logic [SIZE_W-1:0] in_size = '0;
    logic [OFF_W-1:0]  in_off = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [1:0]        out_status;
    logic [OFF_W-1:0]  out_granted;

    t_req   pending_reqs[$];
    t_grant expected_grants[$];
    int     mismatches = 0;
    int     cycles = 0;
    int     results_seen = 0;
    int     hold_off = 0;
    int     send_gap = 0;
    int     recv_gap = 0;
    bit     pause_send = 1'b0;
    int     n_full = 0;
    int     n_fail = 0;

    // Mirror of the block's segment table.
    logic [OFF_W-1:0]  seg_off[MAX_SEGMENTS];
    logic [SIZE_W-1:0] seg_size[MAX_SEGMENTS];
    logic              seg_used[MAX_SEGMENTS];
    int                seg_cnt;

    // Offsets handed out and not yet released, for well-formed release items.
    logic [OFF_W-1:0]  live_offs[$];

    always #5 clk = ~clk;

    first_fit_segment_allocator u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_mode(in_mode), .i_request_size(in_size), .i_block_offset(in_off),
        .o_valid(out_valid), .i_stall(out_stall), .o_status(out_status),
        .o_granted_offset(out_granted)
    );

    function automatic void seg_remove(int idx);
        for (int k = idx; k + 1 < seg_cnt; k++) begin
            seg_off[k] = seg_off[k+1];
            seg_size[k] = seg_size[k+1];
            seg_used[k] = seg_used[k+1];
        end
        seg_cnt--;
    endfunction

    function automatic t_grant predict_grant(t_req r);
        t_grant g;
        g.status = ST_FAIL;
        g.granted = '0;
        if (r.mode == MODE_ALLOC) begin
            if (r.req_size == 0) return g;
            for (int i = 0; i < seg_cnt; i++) begin
                if (seg_used[i] || seg_size[i] < r.req_size) continue;
                if (seg_size[i] != r.req_size) begin
                    if (i + 1 < seg_cnt && !seg_used[i+1]) begin
                        seg_off[i+1] = seg_off[i] + r.req_size[OFF_W-1:0];
                        seg_size[i+1] = seg_size[i+1] + seg_size[i] - r.req_size;
                    end else begin
                        if (seg_cnt >= MAX_SEGMENTS) begin
                            g.status = ST_FULL;
                            return g;
                        end
                        for (int k = seg_cnt; k > i + 1; k--) begin
                            seg_off[k] = seg_off[k-1];
                            seg_size[k] = seg_size[k-1];
                            seg_used[k] = seg_used[k-1];
                        end
                        seg_cnt++;
                        seg_off[i+1] = seg_off[i] + r.req_size[OFF_W-1:0];
                        seg_size[i+1] = seg_size[i] - r.req_size;
                        seg_used[i+1] = 1'b0;
                    end
                    seg_size[i] = r.req_size;
                end
                seg_used[i] = 1'b1;
                g.status = ST_DONE;
                g.granted = seg_off[i];
                return g;
            end
        end else begin
            for (int i = 0; i < seg_cnt; i++) begin
                if (seg_off[i] != r.blk_off) continue;
                seg_used[i] = 1'b0;
                if (i + 1 < seg_cnt && !seg_used[i+1]) begin
                    seg_size[i] = seg_size[i] + seg_size[i+1];
                    seg_remove(i + 1);
                end
                if (i > 0 && !seg_used[i-1]) begin
                    seg_size[i-1] = seg_size[i-1] + seg_size[i];
                    seg_remove(i);
                end
                g.status = ST_DONE;
                return g;
            end
        end
        return g;
    endfunction

    task automatic add_req(logic mode, int unsigned sz, int unsigned off);
        t_req r;
        t_grant g;
        r.mode = mode;
        r.req_size = sz[SIZE_W-1:0];
        r.blk_off = off[OFF_W-1:0];
        g = predict_grant(r);
        if (mode == MODE_ALLOC && g.status == ST_DONE) live_offs.push_back(g.granted);
        if (g.status == ST_FULL) n_full++;
        if (g.status == ST_FAIL) n_fail++;
        pending_reqs.push_back(r);
        expected_grants.push_back(g);
    endtask

    task automatic add_release_live();
        int idx;
        logic [OFF_W-1:0] off;
        idx = $urandom_range(0, live_offs.size() - 1);
        off = live_offs[idx];
        live_offs.delete(idx);
        add_req(MODE_FREE, $urandom, off);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_grants.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Driver: presents queued items, with random gaps between them.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                void'(pending_reqs.pop_front());
                send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                in_valid <= 1'b0;
                if (send_gap == 0 && !pause_send && pending_reqs.size() != 0) begin
                    in_valid <= 1'b1;
                    in_mode <= pending_reqs[0].mode;
                    in_size <= pending_reqs[0].req_size;
                    in_off <= pending_reqs[0].blk_off;
                end
            end else if (!in_valid) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (!pause_send && pending_reqs.size() != 0) begin
                    in_valid <= 1'b1;
                    in_mode <= pending_reqs[0].mode;
                    in_size <= pending_reqs[0].req_size;
                    in_off <= pending_reqs[0].blk_off;
                end
            end
        end
    end

    // Receiver stall: random per item, plus one long hold-off on request.
    always @(posedge clk) begin
        if (rst_n) begin
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                out_stall <= 1'b1;
            end else if (out_valid && !out_stall) begin
                recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                out_stall <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Monitor: compares each delivered item with the oldest prediction.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall) begin
            results_seen <= results_seen + 1;
            if (expected_grants.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected item: status %0d offset %0d", out_status, out_granted);
            end else begin
                if (out_status !== expected_grants[0].status
                        || out_granted !== expected_grants[0].granted) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: expected status %0d offset %0d, got %0d %0d",
                                 expected_grants[0].status, expected_grants[0].granted,
                                 out_status, out_granted);
                end
                void'(expected_grants.pop_front());
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int choice;
        seg_off[0] = '0;
        seg_size[0] = SIZE_W'(HEAP_BYTES);
        seg_used[0] = 1'b0;
        seg_cnt = 1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero size, oversize, whole heap, unknown and free-segment releases.
        add_req(MODE_ALLOC, 0, 16'hFFFF);
        add_req(MODE_ALLOC, HEAP_BYTES + 0, 0);
        add_req(MODE_ALLOC, 131071, 0);
        add_req(MODE_FREE, 0, 0);
        add_req(MODE_ALLOC, HEAP_BYTES, 0);
        add_req(MODE_ALLOC, 1, 0);
        add_req(MODE_FREE, 0, 16'hFFFF);
        add_req(MODE_FREE, 0, 0);
        void'(live_offs.pop_front());
        add_req(MODE_ALLOC, 1, 0);
        add_req(MODE_ALLOC, 65535, 0);
        add_req(MODE_FREE, 0, 1);
        add_req(MODE_FREE, 0, 0);
        live_offs.delete();
        add_req(MODE_FREE, 0, 0);
        add_req(MODE_FREE, 131071, 12345);
        wait_drained();

        // Fill the table with small items to reach the full-table case.
        for (int k = 0; k < 70; k++) add_req(MODE_ALLOC, 1 + (k % 3), 0);
        // Release every other item; freed segments sit between used ones and do not merge with each other.
        for (int k = 0; k < live_offs.size(); k += 2) add_req(MODE_FREE, 0, live_offs[k]);
        wait_drained();

        // Long receiver hold-off while the sender keeps offering items.
        hold_off = 400;
        for (int k = 0; k < 20; k++) add_req(MODE_ALLOC, $urandom_range(1, 64), 0);

        for (int n = 0; n < 1400; n++) begin
            if (n == 700) begin
                pause_send = 1'b1;
                while (expected_grants.size() > pending_reqs.size()) @(posedge clk);
                repeat (20) @(posedge clk);
                pause_send = 1'b0;
            end
            while (pending_reqs.size() > 16) @(posedge clk);
            choice = $urandom_range(0, 99);
            if (choice < 45) begin
                if ($urandom_range(0, 9) == 0)
                    add_req(MODE_ALLOC, $urandom_range(0, 131071), $urandom);
                else
                    add_req(MODE_ALLOC, $urandom_range(1, 2048), $urandom);
            end else if (choice < 88 && live_offs.size() != 0) begin
                add_release_live();
            end else if (choice < 94) begin
                add_req(MODE_FREE, $urandom, $urandom);
            end else begin
                add_req(MODE_ALLOC, 1 << $urandom_range(0, 16), $urandom);
            end
        end

        wait_drained();
        $display("Delivered %0d items: %0d failed fits or lookups, %0d full-table refusals.",
                 results_seen, n_fail, n_full);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
